// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ILC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ILC_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ILC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ilc_pkg.sv
// Types, opcodes and the length bound shared by the length classifier modules.
package ilc_pkg;

   // Longest instruction before the decoder gives up and resynchronizes
   localparam logic [3:0] MAX_INSN_BYTES = 4'd15;

   // Opcode and prefix bytes
   localparam logic [7:0] OP_REX_W    = 8'h48;
   localparam logic [7:0] OP_MOV_LOAD = 8'h8B;
   localparam logic [7:0] OP_GRP5     = 8'hFF;
   localparam logic [7:0] OP_JMP_IND  = 8'h25;
   localparam logic [7:0] OP_CALL     = 8'hE8;
   localparam logic [7:0] OP_OPSIZE   = 8'h66;
   localparam logic [7:0] OP_CS       = 8'h2E;
   localparam logic [7:0] OP_ESCAPE   = 8'h0F;
   localparam logic [7:0] OP_NOP_1F   = 8'h1F;
   localparam logic [7:0] OP_RET      = 8'hC3;
   localparam logic [7:0] OP_REP      = 8'hF3;
   localparam logic [7:0] OP_JMP32    = 8'hE9;
   localparam logic [7:0] OP_JMP8     = 8'hEB;
   localparam logic [7:0] OP_PUSH_RBX = 8'h53;
   localparam logic [7:0] OP_POP_RBX  = 8'h5B;
   localparam logic [7:0] OP_GRP1_IB  = 8'h83;
   localparam logic [7:0] OP_GRP1_IZ  = 8'h81;

   // Result classes; KIND_CONT marks an instruction still in progress
   typedef enum logic [2:0] {
      KIND_RIP   = 3'd0,
      KIND_JUMP  = 3'd1,
      KIND_COND  = 3'd2,
      KIND_CALL  = 3'd3,
      KIND_RET   = 3'd4,
      KIND_OTHER = 3'd5,
      KIND_UNREC = 3'd6,
      KIND_CONT  = 3'd7
   } kind_type;

   // Decoder phases
   typedef enum logic [3:0] {
      PH_START     = 4'd0,
      PH_PREFIX    = 4'd1,
      PH_OPCODE    = 4'd2,
      PH_MODRM     = 4'd3,
      PH_NOP_1F    = 4'd4,
      PH_NOP_MODRM = 4'd5,
      PH_FF        = 4'd6,
      PH_F3        = 4'd7,
      PH_SKIP      = 4'd8,
      PH_DISP8     = 4'd9,
      PH_DISP32    = 4'd10
   } phase_type;

   // Input item
   typedef struct packed {
      logic [7:0]  code_byte;
      logic [63:0] byte_address;
   } req_type;

   // Result item
   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  length;
      logic [63:0] target_address;
      logic        target_valid;
   } rsp_type;

   // Decoded instruction waiting for target computation
   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  length;
      logic [63:0] start_address;
      logic [31:0] rel;
      logic        target_valid;
   } insn_type;

endpackage

// File: design/ilc_front.sv
// Byte-serial decoder: finds instruction boundaries and classifies them.
module ilc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ilc_pkg::req_type req_item,
   output logic             push_valid,
   input  logic             push_ready,
   output ilc_pkg::insn_type push_item
);
   import ilc_pkg::*;

   // Extra bytes after a ModRM byte (displacement and SIB)
   function automatic logic [3:0] modrm_extra(input logic [7:0] m, input logic rip_disp);
      logic [3:0] n;
      n = 4'd0;
      if (m[7:6] == 2'd1) begin
         n = 4'd1;
      end else if (m[7:6] == 2'd2) begin
         n = 4'd4;
      end else if (m[7:6] == 2'd0 && m[2:0] == 3'd5 && rip_disp) begin
         n = 4'd4;
      end
      if (m[2:0] == 3'd4 && m[7:6] != 2'd3) begin
         n = n + 4'd1;
      end
      return n;
   endfunction

   function automatic logic is_modrm_op(input logic [7:0] b);
      return b == 8'h63 || b == 8'h89 || b == 8'h8B || b == 8'h39 ||
             b == 8'h3B || b == 8'h85 || b == 8'h01 || b == 8'h03 ||
             b == 8'h29 || b == 8'h28 || b == 8'h31 || b == 8'h32;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [3:0]  seen_ff, seen_in;
   logic [3:0]  needed_ff, needed_in;
   logic        wide_ff, wide_in;
   logic        half_ff, half_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [31:0] disp_ff, disp_in;
   logic [63:0] start_ff, start_in;
   kind_type    pending_ff, pending_in;

   logic        accept;
   logic [7:0]  b;
   logic [1:0]  disp_slot;
   logic [31:0] disp_or;
   logic [3:0]  skip_n;
   logic        do_prefix;
   logic        do_dispatch;
   kind_type    kind;
   logic [31:0] rel;
   logic        has_target;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign b         = req_item.code_byte;
   assign disp_slot = 2'(4'd4 - needed_ff);
   assign disp_or   = disp_ff | (32'(b) << {disp_slot, 3'b000});

   // Phase machine for one byte
   always_comb begin
      phase_in    = phase_ff;
      needed_in   = needed_ff;
      opcode_in   = opcode_ff;
      disp_in     = disp_ff;
      pending_in  = pending_ff;
      kind        = KIND_CONT;
      rel         = 32'd0;
      has_target  = 1'b0;
      do_prefix   = 1'b0;
      do_dispatch = 1'b0;
      skip_n      = 4'd0;
      if (phase_ff == PH_START) begin
         start_in = req_item.byte_address;
         wide_in  = 1'b0;
         half_in  = 1'b0;
         seen_in  = 4'd1;
      end else begin
         start_in = start_ff;
         wide_in  = wide_ff;
         half_in  = half_ff;
         seen_in  = seen_ff + 4'd1;
      end

      unique case (phase_ff)
         PH_START: begin
            if (b[7:4] == 4'h7) begin
               disp_in = 32'd0; needed_in = 4'd1; pending_in = KIND_COND;
               phase_in = PH_DISP8;
            end else if (b == OP_CALL) begin
               disp_in = 32'd0; needed_in = 4'd4; pending_in = KIND_CALL;
               phase_in = PH_DISP32;
            end else if (b == OP_GRP5) begin
               phase_in = PH_FF;
            end else if (b == OP_REX_W) begin
               wide_in  = 1'b1;
               phase_in = PH_PREFIX;
            end else begin
               do_prefix = 1'b1;
            end
         end
         PH_PREFIX: do_prefix = 1'b1;
         PH_OPCODE: do_dispatch = 1'b1;
         PH_MODRM: begin
            if (b[7:6] == 2'd3) begin
               kind = KIND_OTHER;
            end else if (b[7:6] == 2'd0 && b[2:0] == 3'd5 && opcode_ff == OP_MOV_LOAD &&
                         wide_ff && !half_ff && seen_in == 4'd3) begin
               disp_in = 32'd0; needed_in = 4'd4; pending_in = KIND_RIP;
               phase_in = PH_DISP32;
            end else begin
               skip_n = modrm_extra(b, 1'b1);
               if (skip_n == 4'd0) begin
                  kind = KIND_OTHER;
               end else begin
                  needed_in = skip_n; pending_in = KIND_OTHER; phase_in = PH_SKIP;
               end
            end
         end
         PH_NOP_1F: begin
            if (b == OP_NOP_1F) phase_in = PH_NOP_MODRM;
            else kind = KIND_UNREC;
         end
         PH_NOP_MODRM: begin
            if (b[5:3] != 3'd0) begin
               kind = KIND_UNREC;
            end else if (b[7:6] == 2'd3) begin
               kind = KIND_OTHER;
            end else begin
               skip_n = modrm_extra(b, 1'b0);
               if (skip_n == 4'd0) begin
                  kind = KIND_OTHER;
               end else begin
                  needed_in = skip_n; pending_in = KIND_OTHER; phase_in = PH_SKIP;
               end
            end
         end
         PH_FF: begin
            if (b == OP_JMP_IND) begin
               disp_in = 32'd0; needed_in = 4'd4; pending_in = KIND_JUMP;
               phase_in = PH_DISP32;
            end else begin
               kind = KIND_UNREC;
            end
         end
         PH_F3: kind = (b == OP_RET) ? KIND_RET : KIND_UNREC;
         PH_SKIP: begin
            if (needed_ff != 4'd0) needed_in = needed_ff - 4'd1;
            if (needed_in == 4'd0) kind = pending_ff;
         end
         PH_DISP8: begin
            needed_in  = 4'd0;
            disp_in    = 32'(b);
            rel        = {{24{b[7]}}, b};
            has_target = 1'b1;
            kind       = pending_ff;
         end
         PH_DISP32: begin
            disp_in = disp_or;
            if (needed_ff != 4'd0) needed_in = needed_ff - 4'd1;
            if (needed_in == 4'd0) begin
               rel        = disp_or;
               has_target = 1'b1;
               kind       = pending_ff;
            end
         end
         default: kind = KIND_UNREC;
      endcase

      // Operand-size and CS prefix bytes
      if (do_prefix) begin
         if (b == OP_OPSIZE) begin
            half_in  = 1'b1;
            phase_in = PH_PREFIX;
         end else if (b == OP_CS) begin
            phase_in = PH_OPCODE;
         end else begin
            do_dispatch = 1'b1;
         end
      end

      // Opcode byte
      if (do_dispatch) begin
         opcode_in = b;
         if (b == OP_ESCAPE) begin
            phase_in = PH_NOP_1F;
         end else if (b == OP_PUSH_RBX || b == OP_POP_RBX || (b >= 8'h90 && b <= 8'h98)) begin
            kind = KIND_OTHER;
         end else if (is_modrm_op(b)) begin
            phase_in = PH_MODRM;
         end else if (b[7:3] == 5'b10111) begin
            needed_in  = half_in ? 4'd2 : (wide_in ? 4'd8 : 4'd4);
            pending_in = KIND_OTHER;
            phase_in   = PH_SKIP;
         end else if (b == OP_GRP1_IB) begin
            needed_in = 4'd2; pending_in = KIND_OTHER; phase_in = PH_SKIP;
         end else if (b == OP_GRP1_IZ) begin
            needed_in = 4'd3; pending_in = KIND_OTHER; phase_in = PH_SKIP;
         end else if (b == OP_RET) begin
            kind = KIND_RET;
         end else if (b == OP_REP) begin
            phase_in = PH_F3;
         end else if (b == OP_JMP32) begin
            disp_in = 32'd0; needed_in = 4'd4; pending_in = KIND_JUMP;
            phase_in = PH_DISP32;
         end else if (b == OP_JMP8) begin
            disp_in = 32'd0; needed_in = 4'd1; pending_in = KIND_JUMP;
            phase_in = PH_DISP8;
         end else begin
            kind = KIND_UNREC;
         end
      end

      // Length bound
      if (kind == KIND_CONT && seen_in >= MAX_INSN_BYTES) begin
         kind = KIND_UNREC;
      end
      if (kind == KIND_UNREC) begin
         has_target = 1'b0;
      end
      if (kind != KIND_CONT) begin
         phase_in  = PH_START;
         needed_in = 4'd0;
      end
   end

   // Finished instruction toward the queue
   always_comb begin
      push_valid              = accept && (kind != KIND_CONT);
      push_item.kind          = kind;
      push_item.length        = seen_in;
      push_item.start_address = start_in;
      push_item.rel           = rel;
      push_item.target_valid  = has_target;
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seen_ff    <= seen_in;
         needed_ff  <= needed_in;
         wide_ff    <= wide_in;
         half_ff    <= half_in;
         opcode_ff  <= opcode_in;
         disp_ff    <= disp_in;
         start_ff   <= start_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// File: design/ilc_queue.sv
// Small FIFO of decoded instructions between decoder and target stage.
module ilc_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ilc_pkg::insn_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ilc_pkg::insn_type pop_item
);
   import ilc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   insn_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/ilc_back.sv
// Target stage: computes the absolute target and holds the result item.
module ilc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  ilc_pkg::insn_type pop_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ilc_pkg::rsp_type  rsp_item
);
   import ilc_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    take;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Start + length + sign-extended displacement, zero when there is no target
   always_comb begin
      rsp_in.kind         = pop_item.kind;
      rsp_in.length       = pop_item.length;
      rsp_in.target_valid = pop_item.target_valid;
      if (pop_item.target_valid) begin
         rsp_in.target_address = pop_item.start_address + 64'(pop_item.length) +
                                 {{32{pop_item.rel[31]}}, pop_item.rel};
      end else begin
         rsp_in.target_address = 64'd0;
      end
      rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: design/x86_instruction_length_classifier.sv
// Top level of the x86-64 instruction length classifier.
// Takes one code byte per cycle with its address and gives one result item for each
// instruction boundary found: class, length with prefixes, and the absolute target for
// direct jumps, conditional jumps, calls and the RIP-relative load. Throughput is one
// byte per clock, set by the decoder's phase register, which updates on every byte.
// A result reaches rsp_valid through the result queue and the output register: the edge
// that takes the byte that completes the instruction writes the queue, and from there the
// entry moves through the target adder into the output register. req_ready follows the
// queue: it drops while the queue holds QUEUE_DEPTH results that the consumer has not
// drained, and then every byte waits, whether or not it completes an instruction.
// byte_address is sampled only on the first byte of each instruction.
module x86_instruction_length_classifier #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ilc_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ilc_pkg::rsp_type rsp_item
);
   import ilc_pkg::*;

   logic     push_valid;
   logic     push_ready;
   insn_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   insn_type pop_item;

   // Decoder
   ilc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Decoupling queue
   ilc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Target computation and output register
   ilc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// File: design/ilc_checker.sv
// Port-level checks for the length classifier, bound to the top level.
`include "assert_macros.svh"

module ilc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ilc_pkg::rsp_type rsp_item
);
   import ilc_pkg::*;

   // A stalled result holds
   `ILC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item), "stalled result item changed")

   // Length always within the instruction bound
   `ILC_ASSERT_IMPLIES(a_len_range, clock, reset, rsp_valid, rsp_item.length != 4'd0 && rsp_item.length <= MAX_INSN_BYTES, "result length out of range")

   // Only branch-like classes carry a target
   `ILC_ASSERT_IMPLIES(a_target_kind, clock, reset, rsp_valid && rsp_item.target_valid, rsp_item.kind == KIND_RIP || rsp_item.kind == KIND_JUMP || rsp_item.kind == KIND_COND || rsp_item.kind == KIND_CALL, "target on a class without one")

   // No target means a zero address
   `ILC_ASSERT_IMPLIES(a_target_zero, clock, reset, rsp_valid && !rsp_item.target_valid, rsp_item.target_address == 64'd0, "target address set without target_valid")

   // The in-progress code never leaves the block
   `ILC_ASSERT(a_no_cont, clock, reset, !rsp_valid || rsp_item.kind != KIND_CONT, "result carries the in-progress class")

endmodule

bind x86_instruction_length_classifier ilc_checker u_ilc_checker (.*);
